[rtl/core/session_affinity_table_assert.svh]
// Assertion macros for the session affinity table.
// Used by modules that have clk and rst in scope; no other dependencies.
`ifndef SESSION_AFFINITY_TABLE_ASSERT_SVH
`define SESSION_AFFINITY_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SAT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("session affinity table: assertion failed");

// Next-cycle implication, disabled during reset
`define SAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("session affinity table: assertion failed");

`endif

[rtl/core/sat_pkg.sv]
// Shared types and constants for the session affinity table.
// No dependencies; imported by every module of the block except sat_ram.
package sat_pkg;

  localparam int unsigned DEF_BUCKET_COUNT = 1024;
  localparam int unsigned DEF_WAYS         = 4;
  localparam logic [31:0] HASH_MULT        = 32'h045d9f3b;
  localparam logic [31:0] TIMEOUT_RESET    = 32'd300;
  localparam int unsigned COUNT_OUT_W      = 13;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_SWEEP  = 2'd2,
    KIND_RSVD   = 2'd3   // unused code, answered with status 1
  } kind_t;

  // One slot of a bucket
  typedef struct packed {
    logic        valid;
    logic [31:0] client;
    logic [15:0] link;
    logic [31:0] last_seen;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_MOD,
    S_READ,
    S_UPDATE,
    S_SW_READ,
    S_SW_WRITE,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic hash1;
    logic hash2;
    logic mod_step;
    logic rd_bucket;
    logic update;
    logic sweep_rd;
    logic sweep_wr;
    logic clr_wr;
    logic res_reject;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic reject;
    logic is_sweep;
    logic mod_done;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/session_affinity_table.sv]
// Lookup and insert: HASH1, HASH2, MOD, READ, UPDATE, then DONE loads the result register
// once it is free; no new item is taken before that. If BUCKET_COUNT is not a power of
// two, MOD finds a quotient estimate, a remainder estimate, then the bucket. Rejected
// items and the unused kind go from HASH1 straight to DONE. Sweep: each bucket row is
// read, then written back without its expired ways. Reset (rst, synchronous) starts a
// clearing pass over all rows, taking no item until it ends; session_timeout resets to 300.
module session_affinity_table #(
  parameter int unsigned BUCKET_COUNT = sat_pkg::DEF_BUCKET_COUNT,
  parameter int unsigned WAYS         = sat_pkg::DEF_WAYS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,     // session_timeout
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,    // client_addr[31:0], link_id[47:32], now_sec[79:48]
  input  logic [1:0]  s_axis_tuser,    // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata     // found_link[15:0], status[16], active_entries[29:17]
);
  import sat_pkg::*;

  cmd_t                   cmd;
  sts_t                   sts;
  logic [15:0]            out_found;
  logic                   out_status;
  logic [COUNT_OUT_W-1:0] out_count;

  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sat_dp #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .WAYS         (WAYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_kind     (s_axis_tuser),
    .in_addr     (s_axis_tdata[31:0]),
    .in_link     (s_axis_tdata[47:32]),
    .in_now      (s_axis_tdata[79:48]),
    .out_tready  (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_found   (out_found),
    .out_status  (out_status),
    .out_count   (out_count),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Pack result fields, pad to 32 bits
  assign m_axis_tdata = {2'b00, out_count, out_status, out_found};

endmodule

[rtl/core/sat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sat_ctrl.sv]
// Sequencer for the session affinity table: lookup/insert, sweep, clearing pass.
// Depends on sat_pkg and session_affinity_table_assert.svh.
`include "session_affinity_table_assert.svh"

module sat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sat_pkg::sts_t sts,
  output sat_pkg::cmd_t cmd
);
  import sat_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (sts.idx_last) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_HASH1;
      S_HASH1: begin
        if (sts.reject) begin
          state_next = S_DONE;
        end else if (sts.is_sweep) begin
          state_next = S_SW_READ;
        end else begin
          state_next = S_HASH2;
        end
      end
      S_HASH2:    state_next = S_MOD;
      S_MOD:      if (sts.mod_done) state_next = S_READ;
      S_READ:     state_next = S_UPDATE;
      S_UPDATE:   state_next = S_DONE;
      S_SW_READ:  state_next = S_SW_WRITE;
      S_SW_WRITE: state_next = sts.idx_last ? S_DONE : S_SW_READ;
      S_DONE:     if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR:    cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_HASH1: begin
        cmd.hash1      = 1'b1;
        cmd.res_reject = sts.reject;
      end
      S_HASH2:    cmd.hash2 = 1'b1;
      S_MOD:      cmd.mod_step = 1'b1;
      S_READ:     cmd.rd_bucket = 1'b1;
      S_UPDATE:   cmd.update = 1'b1;
      S_SW_READ:  cmd.sweep_rd = 1'b1;
      S_SW_WRITE: cmd.sweep_wr = 1'b1;
      S_DONE:     cmd.load_out = sts.out_free;
      default:    cmd = '0;
    endcase
  end

  `SAT_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_HASH1)
  `SAT_ASSERT_NEXT(a_clear_exit, state == S_CLEAR, state == S_CLEAR || state == S_IDLE)
  `SAT_ASSERT_IMPL(a_one_ram_op, 1'b1,
                   $onehot0({cmd.update, cmd.sweep_wr, cmd.clr_wr}))

endmodule

[rtl/core/sat_dp.sv]
// Datapath: input and result registers, hash, bucket reduction, bucket RAM,
// way match/expiry logic and entry counter. Depends on sat_pkg, sat_ram
// and session_affinity_table_assert.svh.
`include "session_affinity_table_assert.svh"

module sat_dp #(
  parameter int unsigned BUCKET_COUNT = sat_pkg::DEF_BUCKET_COUNT,
  parameter int unsigned WAYS         = sat_pkg::DEF_WAYS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [31:0]                     cfg_wr_data,
  input  logic [1:0]                      in_kind,
  input  logic [31:0]                     in_addr,
  input  logic [15:0]                     in_link,
  input  logic [31:0]                     in_now,
  input  logic                            out_tready,
  output logic                            out_valid,
  output logic [15:0]                     out_found,
  output logic                            out_status,
  output logic [sat_pkg::COUNT_OUT_W-1:0] out_count,
  input  sat_pkg::cmd_t                   cmd,
  output sat_pkg::sts_t                   sts
);
  import sat_pkg::*;

  localparam int unsigned BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RM_W  = $clog2(WAYS + 1);
  localparam int unsigned SLOTS = BUCKET_COUNT * WAYS;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned ROW_W = WAYS * $bits(entry_t);
  localparam bit          POW2  = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

  // Item and config registers
  logic [1:0]  kind;
  logic [31:0] addr;
  logic [15:0] link;
  logic [31:0] now;
  logic [31:0] timeout;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind <= in_kind;
      addr <= in_addr;
      link <= in_link;
      now  <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  // Input checks
  always_comb begin
    sts.reject   = 1'b0;
    sts.is_sweep = 1'b0;
    case (kind)
      KIND_LOOKUP: sts.reject = (addr == 32'd0);
      KIND_INSERT: sts.reject = (addr == 32'd0) || (link == 16'd0);
      KIND_SWEEP:  sts.is_sweep = 1'b1;
      default:     sts.reject = 1'b1;
    endcase
  end

  // Hash: two registered multiply rounds
  logic [31:0] p1;
  logic [31:0] p2;
  logic [31:0] x1;
  logic [31:0] x2;
  logic [31:0] h;

  assign x1 = addr ^ (addr >> 16);
  assign x2 = p1 ^ (p1 >> 16);
  assign h  = p2 ^ (p2 >> 16);

  always_ff @(posedge clk) begin
    if (cmd.hash1) begin
      p1 <= 32'(x1 * HASH_MULT);
    end
    if (cmd.hash2) begin
      p2 <= 32'(x2 * HASH_MULT);
    end
  end

  // Bucket reduction: mask, or a three-step reciprocal remainder
  logic [BKT_W-1:0] bkt_calc;
  logic [BKT_W-1:0] bucket;

  if (POW2) begin : g_mask
    assign bkt_calc     = h[BKT_W-1:0];
    assign sts.mod_done = 1'b1;
  end else begin : g_rem
    // quotient estimate is low by at most one, so the remainder is below 2*count
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKET_COUNT);
    logic [1:0]       mstep;
    logic [31:0]      q_est;
    logic [BKT_W+1:0] r_est;
    logic [63:0]      prod;
    logic [31:0]      r_full;
    logic [BKT_W+1:0] r_one;

    assign prod     = {32'd0, h} * {32'd0, RECIP};
    assign r_full   = h - 32'(q_est * BUCKET_COUNT);
    assign r_one    = (r_est >= (BKT_W + 2)'(BUCKET_COUNT))
                      ? r_est - (BKT_W + 2)'(BUCKET_COUNT) : r_est;
    assign bkt_calc = (r_one >= (BKT_W + 2)'(BUCKET_COUNT))
                      ? BKT_W'(r_one - (BKT_W + 2)'(BUCKET_COUNT))
                      : BKT_W'(r_one);
    assign sts.mod_done = (mstep == 2'd2);

    always_ff @(posedge clk) begin
      if (cmd.hash2) begin
        mstep <= '0;
      end else if (cmd.mod_step) begin
        mstep <= mstep + 2'd1;
        if (mstep == 2'd0) q_est <= prod[63:32];
        if (mstep == 2'd1) r_est <= (BKT_W + 2)'(r_full);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_step) begin
      bucket <= bkt_calc;
    end
  end

  // Walk index for the clearing pass and sweeps
  logic [BKT_W-1:0] idx;

  assign sts.idx_last = (idx == BKT_W'(BUCKET_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr_wr || cmd.sweep_wr) begin
      idx <= sts.idx_last ? '0 : idx + BKT_W'(1);
    end
  end

  // Bucket RAM: one row holds all ways of a bucket
  entry_t [WAYS-1:0] row_rd;
  entry_t [WAYS-1:0] row_upd;
  entry_t [WAYS-1:0] row_sw;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  ram_wdata;
  logic [BKT_W-1:0]  ram_raddr;
  logic [BKT_W-1:0]  ram_waddr;
  logic              ram_we;

  assign ram_raddr = cmd.sweep_rd ? idx : bucket;
  assign ram_waddr = cmd.update ? bucket : idx;
  assign ram_we    = cmd.update || cmd.sweep_wr || cmd.clr_wr;
  assign ram_wdata = cmd.clr_wr ? '0 : (cmd.sweep_wr ? row_sw : row_upd);
  assign row_rd    = ram_rdata;

  sat_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Per-way match, free and expiry flags
  logic [WAYS-1:0]  hit;
  logic [WAYS-1:0]  free;
  logic [WAYS-1:0]  expd;
  logic [WAY_W-1:0] hit_idx;
  logic [WAY_W-1:0] free_idx;

  always_comb begin
    hit      = '0;
    free     = '0;
    expd     = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = row_rd[w].valid && (row_rd[w].client == addr);
      free[w] = !row_rd[w].valid;
      expd[w] = 32'(now - row_rd[w].last_seen) > timeout;
    end
    // lowest index wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) hit_idx = WAY_W'(w);
      if (free[w]) free_idx = WAY_W'(w);
    end
  end

  // Lookup / insert row update
  logic [15:0] upd_found;
  logic        upd_status;
  logic        upd_add;

  always_comb begin
    row_upd    = row_rd;
    upd_found  = '0;
    upd_status = 1'b0;
    upd_add    = 1'b0;
    case (kind)
      KIND_LOOKUP: begin
        if (|hit && !expd[hit_idx]) begin
          row_upd[hit_idx].last_seen = now;
          upd_found                  = row_rd[hit_idx].link;
        end
      end
      KIND_INSERT: begin
        if (|hit) begin
          row_upd[hit_idx].link      = link;
          row_upd[hit_idx].last_seen = now;
        end else if (|free) begin
          row_upd[free_idx].valid     = 1'b1;
          row_upd[free_idx].client    = addr;
          row_upd[free_idx].link      = link;
          row_upd[free_idx].last_seen = now;
          upd_add                     = 1'b1;
        end else begin
          upd_status = 1'b1;
        end
      end
      default: upd_status = 1'b1;
    endcase
  end

  // Sweep row: drop expired ways
  logic [WAYS-1:0] rm;
  logic [RM_W-1:0] removed;

  always_comb begin
    row_sw = row_rd;
    rm     = '0;
    for (int w = 0; w < WAYS; w++) begin
      rm[w] = row_rd[w].valid && expd[w];
      if (rm[w]) row_sw[w].valid = 1'b0;
    end
    removed = RM_W'($countones(rm));
  end

  // Entry counter
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.update && upd_add) begin
      count <= count + CNT_W'(1);
    end else if (cmd.sweep_wr) begin
      count <= count - CNT_W'(removed);
    end
  end

  // Pending result
  logic [15:0] res_found;
  logic        res_status;

  always_ff @(posedge clk) begin
    if (cmd.res_reject) begin
      res_found  <= '0;
      res_status <= 1'b1;
    end else if (cmd.update) begin
      res_found  <= upd_found;
      res_status <= upd_status;
    end else if (cmd.sweep_wr) begin
      res_found  <= '0;
      res_status <= 1'b0;
    end
  end

  // Output register
  assign sts.out_free = !out_valid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found  <= res_found;
      out_status <= res_status;
      out_count  <= COUNT_OUT_W'(count);
    end
  end

  `SAT_ASSERT_IMPL(a_count_max, 1'b1, count <= CNT_W'(SLOTS))
  `SAT_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid || out_tready)
  `SAT_ASSERT_IMPL(a_sweep_count, cmd.sweep_wr, count >= CNT_W'(removed))

endmodule

[bench/sat_checker.sv]
// Checker for the session affinity table: watches the config port and both item
// streams, predicts each result from its own copy of the table and compares.
// Depends on sat_pkg only.
module sat_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_results,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  localparam int unsigned BUCKETS = DEF_BUCKET_COUNT;
  localparam int unsigned NWAYS   = DEF_WAYS;
  localparam int unsigned SLOTS   = BUCKETS * NWAYS;

  typedef struct packed {
    logic [12:0] active;
    logic        status;
    logic [15:0] link;
  } verdict_t;

  logic [31:0] tmo_limit;
  logic        tbl_valid  [SLOTS];
  logic [31:0] tbl_client [SLOTS];
  logic [15:0] tbl_link   [SLOTS];
  logic [31:0] tbl_seen   [SLOTS];
  logic [12:0] live_count;
  verdict_t    verdict_q[$];

  // Multiply-xorshift hash reduced to a bucket index
  function automatic int unsigned bucket_index(logic [31:0] addr);
    logic [31:0] h;
    h = addr;
    h = ((h >> 16) ^ h) * HASH_MULT;
    h = ((h >> 16) ^ h) * HASH_MULT;
    h = (h >> 16) ^ h;
    return h % BUCKETS;
  endfunction

  function automatic logic aged_out(int unsigned s, logic [31:0] now);
    logic [31:0] d;
    d = now - tbl_seen[s];
    return d > tmo_limit;
  endfunction

  function automatic verdict_t apply_item(logic [1:0] kind, logic [31:0] addr,
                                          logic [15:0] link, logic [31:0] now);
    verdict_t    v;
    int unsigned base;
    int          hit;
    v = '0;
    hit = -1;
    base = bucket_index(addr) * NWAYS;
    for (int w = 0; w < NWAYS; w++)
      if (hit < 0 && tbl_valid[base+w] && tbl_client[base+w] == addr) hit = base + w;
    case (kind)
      KIND_LOOKUP: begin
        if (addr == 0) v.status = 1'b1;
        else if (hit >= 0 && !aged_out(hit, now)) begin
          tbl_seen[hit] = now;
          v.link = tbl_link[hit];
        end
      end
      KIND_INSERT: begin
        if (addr == 0 || link == 0) v.status = 1'b1;
        else if (hit >= 0) begin
          tbl_link[hit] = link;
          tbl_seen[hit] = now;
        end else begin
          v.status = 1'b1;
          for (int w = 0; w < NWAYS; w++)
            if (v.status && !tbl_valid[base+w]) begin
              tbl_valid[base+w]  = 1'b1;
              tbl_client[base+w] = addr;
              tbl_link[base+w]   = link;
              tbl_seen[base+w]   = now;
              live_count++;
              v.status = 1'b0;
            end
        end
      end
      KIND_SWEEP: begin
        for (int s = 0; s < SLOTS; s++)
          if (tbl_valid[s] && aged_out(s, now)) begin
            tbl_valid[s] = 1'b0;
            if (live_count > 0) live_count--;
          end
      end
      default: v.status = 1'b1;
    endcase
    v.active = live_count;
    return v;
  endfunction

  assign pending_results = verdict_q.size();

  always @(posedge clk) begin
    verdict_t got, want;
    logic     bad;
    if (rst) begin
      tmo_limit = TIMEOUT_RESET;
      live_count = '0;
      for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
      verdict_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_wr_en) tmo_limit = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        verdict_q.push_back(apply_item(s_axis_tuser, s_axis_tdata[31:0],
                                       s_axis_tdata[47:32], s_axis_tdata[79:48]));
      // Compare the delivered result against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[29:0];
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          bad = 1'b0;
          if (got.link !== want.link) begin
            $error("found_link expected %0d actual %0d", want.link, got.link);
            bad = 1'b1;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            bad = 1'b1;
          end
          if (got.active !== want.active) begin
            $error("active_entries expected %0d actual %0d", want.active, got.active);
            bad = 1'b1;
          end
          if (bad) fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

[bench/tb.sv]
// Top of the session affinity table bench: clock, reset, stimulus and verdict.
// Depends on sat_pkg, the session_affinity_table RTL and bench/sat_checker.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_count, pending_results, results_seen;

  logic        no_idle = 1'b0;
  logic        hold_off = 1'b0;
  logic [31:0] clock_sec = 32'd1000;
  logic [31:0] client_pool[16];
  int          sweeps_sent = 0;

  always #5 clk = ~clk;

  session_affinity_table dut (.*);

  sat_checker u_checker (.*);

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
  end

  // tvalid stays high after an accept until the next item or an idle cycle
  task automatic send_item(logic [1:0] kind, logic [31:0] addr, logic [15:0] link,
                           logic [31:0] now);
    while (!no_idle && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {now, link, addr};
    do @(posedge clk); while (!s_axis_tready);
    if (kind == KIND_SWEEP) sweeps_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly pool addresses so lookups hit and buckets fill; time creeps forward
  task automatic random_phase(int count);
    logic [1:0]  kind;
    logic [31:0] addr;
    int          r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      kind = (r < 45) ? KIND_LOOKUP : (r < 90) ? KIND_INSERT : (r < 93) ? KIND_SWEEP : KIND_RSVD;
      addr = ($urandom_range(9) < 8) ? client_pool[$urandom_range(15)] : $urandom;
      if ($urandom_range(49) == 0) addr = 32'd0;
      clock_sec = clock_sec + $urandom_range(40);
      if ($urandom_range(99) == 0) clock_sec = $urandom;
      send_item(kind, addr, ($urandom_range(29) == 0) ? 16'd0 : 16'($urandom),
                clock_sec);
    end
  endtask

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < 16; i++) client_pool[i] = $urandom | 32'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every kind, rejects, refresh, expiry
    no_idle <= 1'b1;
    send_item(KIND_LOOKUP, 32'd0, 16'd0, 32'd0);
    send_item(KIND_INSERT, 32'd0, 16'd5, 32'd10);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'd0, 32'd10);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'd10);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 16'd0, 32'd310);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 16'd0, 32'd611);
    send_item(KIND_LOOKUP, 32'd12345, 16'd0, 32'd611);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'd7, 32'd700);
    send_item(KIND_RSVD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(KIND_INSERT, 32'd1, 16'd1, 32'hFFFF_FFF0);
    send_item(KIND_LOOKUP, 32'd1, 16'd0, 32'd20);
    // Ten distinct addresses inserted once each, link set to the index
    for (int i = 2; i < 12; i++) send_item(KIND_INSERT, 32'(i * 1024), 16'(i), 32'd100);
    send_item(KIND_SWEEP, 32'd0, 16'd0, 32'd100);
    send_item(KIND_SWEEP, 32'hFFFF_FFFF, 16'hFFFF, 32'd2000);
    no_idle <= 1'b0;

    // Random phases under several timeouts, extremes included
    write_timeout(32'd0);
    random_phase(60);
    write_timeout(32'hFFFF_FFFF);
    random_phase(60);
    write_timeout(32'd120);

    // Long receiver hold-off while the sender keeps pushing
    hold_off <= 1'b1;
    fork
      begin repeat (300) @(posedge clk); hold_off <= 1'b0; end
      random_phase(30);
    join
    // Sender pause until the table has caught up
    drain_results();
    no_idle <= 1'b1;
    random_phase(120);
    no_idle <= 1'b0;
    write_timeout(32'd60);
    random_phase(130);
    write_timeout(32'd300);
    random_phase(120);

    drain_results();
    $display("Covered %0d results (%0d sweeps) over five timeout settings.",
             results_seen, sweeps_sent);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
